/* sv/agsv_pkg.sv */
// ----------------------------------------------------------------------------
// agsv_pkg
// Shared constants, types and controller/datapath interface structs for the
// angular gap sieve.
// ----------------------------------------------------------------------------
package agsv_pkg;

  localparam int GAP_DEPTH     = 64;
  localparam int BLOCK_DEPTH   = 64;
  localparam int TAN_FRAC_BITS = 24;

  localparam int GAP_AW = $clog2(GAP_DEPTH);
  localparam int GAP_CW = $clog2(GAP_DEPTH + 1);
  localparam int BLK_AW = $clog2(BLOCK_DEPTH);
  localparam int BLK_CW = $clog2(BLOCK_DEPTH + 1);

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  // magnitude of a coordinate difference fits in 32 bits
  localparam int DIV_NW  = COORD_W;
  localparam int DIV_QW  = DIV_NW + TAN_FRAC_BITS;
  localparam int DIV_CNW = $clog2(DIV_QW);

  typedef logic signed [31:0]        tan_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  localparam tan_t TAN_MAX = 32'sh7FFF_FFFF;
  localparam tan_t TAN_MIN = 32'sh8000_0000;
  localparam tan_t TAN_ONE = tan_t'(64'sd1 << TAN_FRAC_BITS);

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_SIEVE   = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef struct packed {
    tan_t hi;
    tan_t lo;
  } span_t;

  typedef struct packed {
    logic latch_in;
    logic div_start;
    logic div_pt;
    logic store_tan;
    logic restart;
    logic scan_init;
    logic scan_rd;
    logic scan_next;
    logic set_ovf;
    logic shift_init;
    logic shift_rd;
    logic shift_wr;
    logic ins_wr;
    logic sv_init;
    logic src_rd;
    logic cur_load;
    logic blk_rd;
    logic sv_skip;
    logic sv_drop;
    logic sv_emit;
    logic sv_split;
    logic sv_clip;
    logic flush;
    logic copy_wr;
    logic sv_fin;
    logic em_init;
    logic em_load;
    logic em_none;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_end;
    logic scan_less;
    logic scan_eq;
    logic blk_full;
    logic shift_end;
    logic src_end;
    logic blk_end;
    logic blk_pass;
    logic gap_empty;
    logic blk_past;
    logic create;
    logic gap_room;
    logic gap_none;
    logic em_last;
    logic out_free;
  } sts_t;

endpackage

/* sv/agsv_div.sv */
// ----------------------------------------------------------------------------
// agsv_div
// Restoring divider, one quotient bit per cycle, giving a saturated Q8.24
// tangent from two signed coordinate differences.
// ----------------------------------------------------------------------------
module agsv_div import agsv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  diff_t num,
  input  diff_t den,
  output logic  done,
  output tan_t  quo
);

  logic               busy_r;
  logic               fin_r;
  logic               done_r;
  logic [DIV_CNW-1:0] cnt_r;
  logic [DIV_NW-1:0]  rem_r;
  logic [DIV_NW-1:0]  dmag_r;
  logic [DIV_QW-1:0]  dvd_r;
  logic [DIV_QW-1:0]  q_r;
  logic               neg_r;
  tan_t               res_r;

  diff_t              nabs;
  diff_t              dabs;
  logic [DIV_NW:0]    trial;
  logic [DIV_NW:0]    tdiff;
  logic               ge;
  logic [DIV_NW-1:0]  rem_nxt;
  logic               big_neg;
  logic               big_pos;
  tan_t               sat_res;
  tan_t               zero_res;

  always_comb begin
    nabs     = (num < 0) ? -num : num;
    dabs     = (den < 0) ? -den : den;
    trial    = {rem_r, dvd_r[DIV_QW-1]};
    tdiff    = trial - {1'b0, dmag_r};
    ge       = (trial >= {1'b0, dmag_r});
    rem_nxt  = ge ? tdiff[DIV_NW-1:0] : trial[DIV_NW-1:0];
    big_neg  = (q_r[DIV_QW-1:32] != '0) || (q_r[31] && (q_r[30:0] != '0));
    big_pos  = (q_r[DIV_QW-1:31] != '0);
    if (neg_r) begin
      sat_res = big_neg ? TAN_MIN : tan_t'(32'd0 - q_r[31:0]);
    end else begin
      sat_res = big_pos ? TAN_MAX : tan_t'(q_r[31:0]);
    end
    if (num > 0) begin
      zero_res = TAN_MAX;
    end else if (num < 0) begin
      zero_res = TAN_MIN;
    end else begin
      zero_res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        if (den == 0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNW'(DIV_QW - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      dvd_r  <= {nabs[DIV_NW-1:0], {TAN_FRAC_BITS{1'b0}}};
      q_r    <= '0;
      dmag_r <= dabs[DIV_NW-1:0];
      neg_r  <= (num < 0) != (den < 0);
      res_r  <= zero_res;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DIV_QW-2:0], 1'b0};
      q_r   <= {q_r[DIV_QW-2:0], ge};
    end
    if (fin_r) begin
      res_r <= sat_res;
    end
  end

  assign done = done_r;
  assign quo  = res_r;

endmodule

/* sv/agsv_dp.sv */
// ----------------------------------------------------------------------------
// agsv_dp
// Sieve datapath: input latch, tangent divider, sorted block store, ping-pong
// gap store, sweep registers and output register.
// ----------------------------------------------------------------------------
module agsv_dp import agsv_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  output sts_t          sts,
  input  coord_t        centre_x,
  input  coord_t        centre_y,
  input  logic [130:0]  in_item,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [63:0]   out_data,
  output logic          out_gap_valid,
  output logic          out_last,
  output logic          out_ovf
);

  // input latch
  coord_t      p0x_r, p0y_r, p1x_r, p1y_r;
  logic [2:0]  oct_r;

  // new block
  tan_t        tan_a_r;
  tan_t        new_lo_r;
  tan_t        new_hi_r;

  // block store
  span_t       blk_mem [BLOCK_DEPTH];
  span_t       blk_rd_r;
  logic [BLK_CW-1:0] blk_count_r;
  logic [BLK_CW-1:0] scan_k_r;
  logic [BLK_CW-1:0] shift_j_r;
  logic [BLK_CW-1:0] bi_r;

  // gap store, two banks
  span_t       gap_mem [2*GAP_DEPTH];
  span_t       gap_rd_r;
  logic        fresh_hit_r;
  logic        fresh_r;
  logic        bank_r;
  logic [GAP_CW-1:0] gap_count_r;
  logic [GAP_CW-1:0] src_idx_r;
  logic [GAP_CW-1:0] src_n_r;
  logic [GAP_CW-1:0] dst_idx_r;
  tan_t        cur_lo_r;
  tan_t        cur_hi_r;
  logic        ovf_r;

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_gv_r;
  logic        out_last_r;
  logic        out_ovf_r;

  coord_t      px, py;
  diff_t       dx, dy, dnum, dden;
  logic        div_done;
  tan_t        quo;
  tan_t        t_lo, t_hi;
  span_t       gap_q;
  tan_t        bs, be, sv_lo, sv_hi;
  logic        cov_lo, cov_hi;
  logic        gap_we;
  logic [GAP_AW:0] gap_wa;
  span_t       gap_wd;
  logic        blk_we;
  logic [BLK_AW-1:0] blk_wa;
  span_t       blk_wd;
  logic        blk_re;
  logic [BLK_AW-1:0] blk_ra;
  logic [BLK_CW-1:0] j_dec;

  always_comb begin
    px = cmd.div_pt ? p1x_r : p0x_r;
    py = cmd.div_pt ? p1y_r : p0y_r;
    dx = diff_t'(px) - diff_t'(centre_x);
    dy = diff_t'(py) - diff_t'(centre_y);
    case (oct_r)
      3'd0:    begin dnum = dy;  dden = -dx; end
      3'd1:    begin dnum = dy;  dden = dx;  end
      3'd2:    begin dnum = -dy; dden = -dx; end
      3'd3:    begin dnum = -dy; dden = dx;  end
      3'd4:    begin dnum = -dx; dden = -dy; end
      3'd5:    begin dnum = dx;  dden = -dy; end
      3'd6:    begin dnum = -dx; dden = dy;  end
      default: begin dnum = dx;  dden = dy;  end
    endcase
  end

  agsv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dnum),
    .den   (dden),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    t_lo  = (tan_a_r < quo) ? tan_a_r : quo;
    t_hi  = (tan_a_r < quo) ? quo : tan_a_r;
    gap_q = fresh_hit_r ? span_t'{hi: TAN_ONE, lo: '0} : gap_rd_r;
    bs    = blk_rd_r.lo;
    be    = blk_rd_r.hi;
    cov_lo = (bs <= cur_lo_r);
    cov_hi = (be >= cur_hi_r);
    sv_lo = (cov_lo && (be > cur_lo_r)) ? be : cur_lo_r;
    sv_hi = (cov_hi && (bs < cur_hi_r)) ? bs : cur_hi_r;
    j_dec = shift_j_r - 1'b1;
  end

  // block store ports
  always_comb begin
    blk_we = cmd.shift_wr || cmd.ins_wr;
    blk_wa = cmd.shift_wr ? shift_j_r[BLK_AW-1:0] : scan_k_r[BLK_AW-1:0];
    blk_wd = cmd.shift_wr ? blk_rd_r : span_t'{hi: new_hi_r, lo: new_lo_r};
    blk_re = cmd.scan_rd || cmd.shift_rd || cmd.blk_rd;
    if (cmd.scan_rd) begin
      blk_ra = scan_k_r[BLK_AW-1:0];
    end else if (cmd.shift_rd) begin
      blk_ra = j_dec[BLK_AW-1:0];
    end else begin
      blk_ra = bi_r[BLK_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_wa] <= blk_wd;
    end
    if (blk_re) begin
      blk_rd_r <= blk_mem[blk_ra];
    end
  end

  // gap store ports: sweep reads bank_r and writes the other bank
  always_comb begin
    gap_we = cmd.sv_emit || cmd.sv_split || cmd.flush || cmd.copy_wr;
    gap_wa = {~bank_r, dst_idx_r[GAP_AW-1:0]};
    if (cmd.sv_emit) begin
      gap_wd = span_t'{hi: sv_hi, lo: sv_lo};
    end else if (cmd.sv_split) begin
      gap_wd = span_t'{hi: bs, lo: cur_lo_r};
    end else if (cmd.flush) begin
      gap_wd = span_t'{hi: cur_hi_r, lo: cur_lo_r};
    end else begin
      gap_wd = gap_q;
    end
  end

  always_ff @(posedge clk) begin
    if (gap_we) begin
      gap_mem[gap_wa] <= gap_wd;
    end
    if (cmd.src_rd) begin
      gap_rd_r    <= gap_mem[{bank_r, src_idx_r[GAP_AW-1:0]}];
      fresh_hit_r <= fresh_r && (src_idx_r == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_count_r <= '0;
      gap_count_r <= GAP_CW'(1);
      fresh_r     <= 1'b1;
      bank_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      scan_k_r    <= '0;
      shift_j_r   <= '0;
      bi_r        <= '0;
      src_idx_r   <= '0;
      src_n_r     <= '0;
      dst_idx_r   <= '0;
    end else begin
      if (cmd.restart) begin
        blk_count_r <= '0;
        gap_count_r <= GAP_CW'(1);
        fresh_r     <= 1'b1;
        ovf_r       <= 1'b0;
      end
      if (cmd.scan_init) scan_k_r <= '0;
      if (cmd.scan_next) scan_k_r <= scan_k_r + 1'b1;
      if (cmd.set_ovf)   ovf_r <= 1'b1;
      if (cmd.shift_init) shift_j_r <= blk_count_r;
      if (cmd.shift_wr)  shift_j_r <= j_dec;
      if (cmd.ins_wr)    blk_count_r <= blk_count_r + 1'b1;
      if (cmd.sv_init) begin
        bi_r      <= '0;
        src_idx_r <= '0;
        src_n_r   <= gap_count_r;
        dst_idx_r <= '0;
      end
      if (cmd.src_rd) src_idx_r <= src_idx_r + 1'b1;
      if (cmd.sv_skip || cmd.sv_split || cmd.sv_clip) bi_r <= bi_r + 1'b1;
      if (cmd.sv_drop) gap_count_r <= gap_count_r - 1'b1;
      if (cmd.sv_split) gap_count_r <= gap_count_r + 1'b1;
      if (gap_we) dst_idx_r <= dst_idx_r + 1'b1;
      if (cmd.sv_fin) begin
        bank_r      <= ~bank_r;
        fresh_r     <= 1'b0;
        blk_count_r <= '0;
      end
      if (cmd.em_init) src_idx_r <= '0;
      if (cmd.em_load || cmd.em_none) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      p0x_r <= coord_t'(in_item[31:0]);
      p0y_r <= coord_t'(in_item[63:32]);
      p1x_r <= coord_t'(in_item[95:64]);
      p1y_r <= coord_t'(in_item[127:96]);
      oct_r <= in_item[130:128];
    end
    if (cmd.store_tan) begin
      if (!cmd.div_pt) begin
        tan_a_r <= quo;
      end else begin
        new_lo_r <= (t_lo == TAN_MIN) ? t_lo : t_lo - 1;
        new_hi_r <= (t_hi == TAN_MAX) ? t_hi : t_hi + 1;
      end
    end
    if (cmd.cur_load) begin
      cur_lo_r <= gap_q.lo;
      cur_hi_r <= gap_q.hi;
    end
    if (cmd.sv_clip || cmd.sv_drop || cmd.sv_emit) begin
      cur_lo_r <= sv_lo;
      cur_hi_r <= sv_hi;
    end
    if (cmd.sv_split) begin
      cur_lo_r <= be;
    end
    if (cmd.em_load) begin
      out_data_r <= {gap_q.hi, gap_q.lo};
      out_gv_r   <= 1'b1;
      out_last_r <= (src_idx_r == gap_count_r);
      out_ovf_r  <= ovf_r;
    end
    if (cmd.em_none) begin
      out_data_r <= '0;
      out_gv_r   <= 1'b0;
      out_last_r <= 1'b1;
      out_ovf_r  <= ovf_r;
    end
  end

  always_comb begin
    sts.div_done  = div_done;
    sts.scan_end  = (scan_k_r == blk_count_r);
    sts.scan_less = (blk_rd_r.lo < new_lo_r) ||
                    ((blk_rd_r.lo == new_lo_r) && (blk_rd_r.hi < new_hi_r));
    sts.scan_eq   = (blk_rd_r.lo == new_lo_r) && (blk_rd_r.hi == new_hi_r);
    sts.blk_full  = (blk_count_r == BLK_CW'(BLOCK_DEPTH));
    sts.shift_end = (shift_j_r == scan_k_r);
    sts.src_end   = (src_idx_r == src_n_r);
    sts.blk_end   = (bi_r == blk_count_r);
    sts.blk_pass  = (be < cur_lo_r);
    sts.gap_empty = (sv_hi <= sv_lo);
    sts.blk_past  = (be > sv_hi);
    sts.create    = !cov_lo && !cov_hi;
    sts.gap_room  = (gap_count_r < GAP_CW'(GAP_DEPTH));
    sts.gap_none  = (gap_count_r == '0);
    sts.em_last   = (src_idx_r == gap_count_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_gap_valid = out_gv_r;
  assign out_last      = out_last_r;
  assign out_ovf       = out_ovf_r;

endmodule

/* sv/agsv_ctrl.sv */
// ----------------------------------------------------------------------------
// agsv_ctrl
// Sequencer for add, sieve and restart items: drives datapath commands from
// its state and the datapath status.
// ----------------------------------------------------------------------------
module agsv_ctrl import agsv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV0_GO, ST_DIV0_W, ST_DIV1_GO, ST_DIV1_W,
    ST_SCAN, ST_SCAN_CMP, ST_PLACE, ST_SHIFT, ST_SHIFT_WR,
    ST_VLOAD, ST_VLOAD_W, ST_VBLK, ST_VBLK_W, ST_VFLUSH,
    ST_VCOPY, ST_VCOPY_W, ST_VFIN, ST_ERD, ST_ELD, ST_ENONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          case (op_t'(in_op))
            OP_ADD:     state_nxt = ST_DIV0_GO;
            OP_SIEVE: begin
              cmd.sv_init = 1'b1;
              state_nxt   = ST_VLOAD;
            end
            OP_RESTART: cmd.restart = 1'b1;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV0_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV0_W;
      end
      ST_DIV0_W: begin
        if (sts.div_done) begin
          cmd.store_tan = 1'b1;
          state_nxt     = ST_DIV1_GO;
        end
      end
      ST_DIV1_GO: begin
        cmd.div_pt    = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV1_W;
      end
      ST_DIV1_W: begin
        cmd.div_pt = 1'b1;
        if (sts.div_done) begin
          cmd.store_tan = 1'b1;
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = ST_PLACE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (sts.scan_less) begin
          cmd.scan_next = 1'b1;
          state_nxt     = ST_SCAN;
        end else if (sts.scan_eq) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (sts.blk_full) begin
          cmd.set_ovf = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.shift_init = 1'b1;
          state_nxt      = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sts.shift_end) begin
          cmd.ins_wr = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.shift_rd = 1'b1;
          state_nxt    = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = ST_SHIFT;
      end
      ST_VLOAD: begin
        if (sts.src_end) begin
          state_nxt = ST_VFIN;
        end else begin
          cmd.src_rd = 1'b1;
          state_nxt  = ST_VLOAD_W;
        end
      end
      ST_VLOAD_W: begin
        cmd.cur_load = 1'b1;
        state_nxt    = ST_VBLK;
      end
      ST_VBLK: begin
        if (sts.blk_end) begin
          state_nxt = ST_VFLUSH;
        end else begin
          cmd.blk_rd = 1'b1;
          state_nxt  = ST_VBLK_W;
        end
      end
      ST_VBLK_W: begin
        state_nxt = ST_VBLK;
        if (sts.blk_pass) begin
          cmd.sv_skip = 1'b1;
        end else if (sts.gap_empty) begin
          cmd.sv_drop = 1'b1;
          state_nxt   = ST_VLOAD;
        end else if (sts.blk_past) begin
          cmd.sv_emit = 1'b1;
          state_nxt   = ST_VLOAD;
        end else if (sts.create) begin
          if (sts.gap_room) begin
            cmd.sv_split = 1'b1;
          end else begin
            cmd.set_ovf = 1'b1;
            cmd.sv_skip = 1'b1;
          end
        end else begin
          cmd.sv_clip = 1'b1;
        end
      end
      ST_VFLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_VCOPY;
      end
      ST_VCOPY: begin
        if (sts.src_end) begin
          state_nxt = ST_VFIN;
        end else begin
          cmd.src_rd = 1'b1;
          state_nxt  = ST_VCOPY_W;
        end
      end
      ST_VCOPY_W: begin
        cmd.copy_wr = 1'b1;
        state_nxt   = ST_VCOPY;
      end
      ST_VFIN: begin
        cmd.sv_fin  = 1'b1;
        cmd.em_init = 1'b1;
        state_nxt   = sts.gap_none ? ST_ENONE : ST_ERD;
      end
      ST_ERD: begin
        cmd.src_rd = 1'b1;
        state_nxt  = ST_ELD;
      end
      ST_ELD: begin
        if (sts.out_free) begin
          cmd.em_load = 1'b1;
          state_nxt   = sts.em_last ? ST_IDLE : ST_ERD;
        end
      end
      ST_ENONE: begin
        if (sts.out_free) begin
          cmd.em_none = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/angular_gap_sieve_top.sv */
// ----------------------------------------------------------------------------
// angular_gap_sieve_top
// Visibility sieve: tangent-space gap list cut by stored wall segments.
//
// in_* beats carry one item: tuser is the operation (add, sieve, restart),
// tdata the two segment endpoints and the octant. An add beat runs two
// serial divisions (one quotient bit per cycle, no division on a zero divisor),
// then walks the sorted block store and shifts entries up to insert the
// new block; an equal stored block ends the add, a full store sets overflow.
// A sieve beat merges the block store into the gap list, then puts out one
// out_* beat per surviving gap, tlast on the final one, or a single beat
// with gap_valid low when none survives. Restart is acted on as its beat is
// taken. The user must set the centre through the cfg_ APB port only while
// the block is idle; the block itself does not enforce this.
// in_tready is high only between items. The result sits in an output
// register, so the next item is taken while the last result waits; a
// stalled receiver holds the beats of a following sieve until it drains.
// Reset leaves the gap list at [0,1], the block store empty, overflow low;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module angular_gap_sieve_top import agsv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] seg_start_x, [63:32] seg_start_y, [95:64] seg_end_x,
  // [127:96] seg_end_y, [130:128] octant, [135:131] zero
  input  logic [135:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] gap_start, [63:32] gap_end
  output logic [63:0]  out_tdata,
  // [0] gap_valid, [1] overflow
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  coord_t centre_x_r;
  coord_t centre_y_r;
  cmd_t   cmd;
  sts_t   sts;
  logic   gap_valid;
  logic   ovf;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? centre_y_r : centre_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= '0;
      centre_y_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2]) begin
        centre_y_r <= cfg_pwdata;
      end else begin
        centre_x_r <= cfg_pwdata;
      end
    end
  end

  agsv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  agsv_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .centre_x      (centre_x_r),
    .centre_y      (centre_y_r),
    .in_item       (in_tdata[130:0]),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_data      (out_tdata),
    .out_gap_valid (gap_valid),
    .out_last      (out_tlast),
    .out_ovf       (ovf)
  );

  assign out_tuser = {ovf, gap_valid};

  // an empty-list result is always the only and last beat of its run
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == '0))
    else $error("empty gap result not last or not zero");

  // results come out only after the item that caused them has been taken
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !in_tready || out_tlast)
    else $error("result started while idle");

  // a stored gap never leaves with its end at or below its start
  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> $signed(out_tdata[63:32]) > $signed(out_tdata[31:0]))
    else $error("emitted gap is empty");

endmodule
